// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the core and divider rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rpn_pkg.sv -----
package rpn_pkg;

    // data path and stack defaults
    localparam int DATA_W        = 8;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int DIV_STEPS     = 8;
    localparam logic [2:0] DIV_LAST_STEP = 3'(DIV_STEPS - 1);

    // token kinds
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_DIVZ  = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    // input request
    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_req;

    // output request
    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [1:0]               status;
    } t_rsp;

    // stack cell move
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_UP,
        CELL_FROM_DOWN
    } t_cell_cmd;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FINISH
    } t_state;

    // divider start
    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] dividend;
        logic signed [DATA_W-1:0] divisor;
    } t_div_cmd;

    // divider completion
    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/postfix_expression_evaluator_core.sv -----
// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+--------------------------
// in       | input     | i_in_valid / o_in_stall      | i_in_req  (op, value, last)
// out      | output    | o_out_valid / i_out_stall    | o_out_req (result, status)
//
// an operand or add/subtract/multiply token passes S_IDLE and S_EXEC; a divide also
//   waits in S_DIV on the 8-step restoring divider; a last mark adds S_FINISH to emit
// the stack is a row of shift cells, the top in cell 0, all cells moved together
// i_rst_n is synchronous; it clears sequencer, count, error, divider and handshake state only
// a finished result waits in the output register; a stalled output holds only
//   the next last-marked token, other tokens are still taken

`include "assert_macros.svh"

module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  rpn_pkg::t_req i_in_req,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output rpn_pkg::t_rsp o_out_req,
    input  logic          i_out_stall
);
    import rpn_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [1:0]     r_err, n_err;
    t_req           r_tok;
    logic           r_out_valid;
    t_rsp           r_out;

    t_cell_cmd                top_cmd, rest_cmd;
    logic signed [DATA_W-1:0] top_in;
    logic signed [DATA_W-1:0] w_cell [STACK_DEPTH];
    logic signed [DATA_W-1:0] d_op, e_op;
    logic signed [2*DATA_W-1:0] prod;
    t_div_cmd                 div_cmd;
    t_div_rsp                 div_rsp;
    logic                     in_acc;
    logic                     out_busy;
    logic                     fin_load;
    t_rsp                     fin_rsp;

    // stack cells, top in cell 0
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] up, down;
        t_cell_cmd                cmd;
        if (g == 0) begin : g_top
            assign up  = top_in;
            assign cmd = top_cmd;
        end else begin : g_mid
            assign up  = w_cell[g-1];
            assign cmd = rest_cmd;
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign down = w_cell[g];
        end else begin : g_lower
            assign down = w_cell[g+1];
        end
        rpn_cell u_cell (
            .i_clk  (i_clk),
            .i_cmd  (cmd),
            .i_up   (up),
            .i_down (down),
            .o_data (w_cell[g])
        );
    end

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_rsp   (div_rsp)
    );

    assign d_op       = w_cell[0];
    assign e_op       = w_cell[1];
    assign prod       = (2*DATA_W)'(e_op) * (2*DATA_W)'(d_op);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_busy   = r_out_valid && i_out_stall;

    // sequencer: next state, stack moves and error tracking
    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_err            = r_err;
        top_cmd          = CELL_HOLD;
        rest_cmd         = CELL_HOLD;
        top_in           = r_tok.value;
        div_cmd.start    = 1'b0;
        div_cmd.dividend = e_op;
        div_cmd.divisor  = d_op;
        fin_load         = 1'b0;
        fin_rsp.result   = (r_count == '0) ? '0 : w_cell[0];
        fin_rsp.status   = (r_count == '0 && r_err == ST_OK) ? ST_UNDER : r_err;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = r_tok.last ? S_FINISH : S_IDLE;
                priority if (r_tok.op == OP_PUSH) begin
                    if (r_count == CW'(STACK_DEPTH)) begin
                        if (r_err == ST_OK) n_err = ST_OVER;
                    end else begin
                        top_cmd  = CELL_FROM_UP;
                        rest_cmd = CELL_FROM_UP;
                        n_count  = r_count + CW'(1);
                    end
                end else if (r_tok.op == OP_ADD || r_tok.op == OP_SUB ||
                             r_tok.op == OP_MUL || r_tok.op == OP_DIV) begin
                    if (r_count < CW'(2)) begin
                        if (r_err == ST_OK) n_err = ST_UNDER;
                    end else if (r_tok.op == OP_DIV) begin
                        if (d_op == '0) begin
                            if (r_err == ST_OK) n_err = ST_DIVZ;
                        end else begin
                            div_cmd.start = 1'b1;
                            n_state       = S_DIV;
                        end
                    end else begin
                        // pop two, push the wrapped result
                        top_cmd  = CELL_FROM_UP;
                        rest_cmd = CELL_FROM_DOWN;
                        n_count  = r_count - CW'(1);
                        if (r_tok.op == OP_ADD) begin
                            top_in = e_op + d_op;
                        end else if (r_tok.op == OP_SUB) begin
                            top_in = e_op - d_op;
                        end else begin
                            top_in = prod[DATA_W-1:0];
                        end
                    end
                end else begin
                    // unused codes leave the stack alone
                    n_count = r_count;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    top_cmd  = CELL_FROM_UP;
                    rest_cmd = CELL_FROM_DOWN;
                    top_in   = div_rsp.quot;
                    n_count  = r_count - CW'(1);
                    n_state  = r_tok.last ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH: begin
                if (!out_busy) begin
                    fin_load = 1'b1;
                    n_count  = '0;
                    n_err    = ST_OK;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tok <= i_in_req;
        end
        if (fin_load) begin
            r_out <= fin_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(STACK_DEPTH),
                   "stack count beyond depth")
    `ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, r_state == S_FINISH && !out_busy,
                 o_out_valid && r_count == '0 && r_err == ST_OK,
                 "finish did not emit and clear")
    `ASSERT_SAME(a_div_in_wait, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV,
                 "divider result outside divide wait")

endmodule

// ----- rtl/rpn_cell.sv -----
module rpn_cell (
    input  logic                              i_clk,
    input  rpn_pkg::t_cell_cmd                i_cmd,
    input  logic signed [rpn_pkg::DATA_W-1:0] i_up,
    input  logic signed [rpn_pkg::DATA_W-1:0] i_down,
    output logic signed [rpn_pkg::DATA_W-1:0] o_data
);
    import rpn_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    // pick the entry from a neighbor or keep it
    always_comb begin
        unique case (i_cmd)
            CELL_FROM_UP:   n_data = i_up;
            CELL_FROM_DOWN: n_data = i_down;
            default:        n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- rtl/rpn_div.sv -----
`include "assert_macros.svh"

module rpn_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpn_pkg::t_div_cmd i_cmd,
    output rpn_pkg::t_div_rsp o_rsp
);
    import rpn_pkg::*;

    logic [DATA_W:0]          r_rem;
    logic [DATA_W-1:0]        r_quo;
    logic [DATA_W-1:0]        r_dvs;
    logic                     r_neg;
    logic [2:0]               r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic signed [DATA_W-1:0] r_q;

    logic [DATA_W:0]   rem_sh;
    logic              fits;
    logic [DATA_W:0]   n_rem;
    logic [DATA_W-1:0] n_quo;

    // magnitude of a signed byte, -128 maps to 128
    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    // one restoring step per cycle while busy
    always_comb begin
        rem_sh = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
        fits   = rem_sh >= {1'b0, r_dvs};
        n_rem  = fits ? rem_sh - {1'b0, r_dvs} : rem_sh;
        n_quo  = {r_quo[DATA_W-2:0], fits};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == DIV_LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // data path, quotient truncates toward zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= '0;
            r_quo <= mag(i_cmd.dividend);
            r_dvs <= mag(i_cmd.divisor);
            r_neg <= i_cmd.dividend[DATA_W-1] ^ i_cmd.divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (r_cnt == DIV_LAST_STEP) begin
                r_q <= r_neg ? DATA_W'(-n_quo) : DATA_W'(n_quo);
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    `ASSERT_SAME(a_div_no_restart, i_clk, i_rst_n, i_cmd.start, !r_busy && !r_done, "divider started while busy")

endmodule
